// ===== design/pkl_pkg.sv =====
// Package for the positional key list: field widths, operation and status
// codes, sequencer state encoding and the default capacity.
// No dependencies; imported by the interfaces and the top level.
package pkl_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned RPOS_W   = 6;
  localparam int unsigned ECOUNT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_BADPOS   = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_UP   = 5'b00010,
    S_DOWN = 5'b00100,
    S_SRCH = 5'b01000,
    S_PUT  = 5'b10000
  } state_e;

endpackage

// ===== design/pkl_if.sv =====
// Valid/ready channel interfaces for list requests and their results.
// Depends on pkl_pkg for the field widths.
interface pkl_req_if import pkl_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [KEY_W-1:0] account_key;
  logic [POS_W-1:0] position;
  logic             append;

  modport source (output valid, op, account_key, position, append, input ready);
  modport sink   (input valid, op, account_key, position, append, output ready);
endinterface

interface pkl_rsp_if import pkl_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [RPOS_W-1:0]   result_position;
  logic [ECOUNT_W-1:0] entry_count;

  modport source (output valid, status, result_position, entry_count, input ready);
  modport sink   (input valid, status, result_position, entry_count, output ready);
endinterface

// ===== design/pkl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pkl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/positional_key_list.sv =====
// Positional key list: ordered list of 32-bit account keys with bounded capacity.
// Depends on pkl_pkg, pkl_if (request/result channels) and pkl_ram (key store).
//
// Usage: one request on req_i (op, account_key, position, append) yields exactly
// one result on rsp_o (status, result_position, entry_count). Insert places a key
// at a position (or at the end with append) and shifts later keys up; remove
// deletes a position and shifts later keys down; search returns the lowest
// matching position. Refused and trivial requests answer in the cycle after
// acceptance. One key moves or is compared per cycle through the single RAM port
// pair. Requests are handled one at a time; req_i.ready is high only when the
// sequencer is idle and the result register is free or being emptied. A stalled
// result simply holds in its register and blocks the next request. Reset empties
// the list; stored keys need no clearing.
module positional_key_list import pkl_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pkl_req_if.sink   req_i,
  pkl_rsp_if.source rsp_o
);

  localparam int unsigned AW   = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = CW > POS_W ? CW : POS_W;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] rd_q, rd_d;
  logic [AW-1:0] wa_q, wa_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic rd_act_q, rd_act_d;
  logic pend_q, pend_d;

  logic out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [RPOS_W-1:0] out_rpos_q, out_rpos_d;
  logic [ECOUNT_W-1:0] out_count_q, out_count_d;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [KEY_W-1:0] ram_wdata, ram_rdata;

  logic accept;
  logic fin;
  status_e fin_status;
  logic [RPOS_W-1:0] fin_rpos;
  logic [CMPW-1:0] pos_ext, cnt_ext, eff_pos;
  logic [AW-1:0] last_idx;
  op_e req_op;

  pkl_ram #(
    .WIDTH(KEY_W),
    .DEPTH(CAPACITY)
  ) u_key_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_i.ready = (state_q == S_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign req_op      = op_e'(req_i.op);
  assign pos_ext     = CMPW'(req_i.position);
  assign cnt_ext     = CMPW'(count_q);
  assign eff_pos     = req_i.append ? cnt_ext : pos_ext;
  assign last_idx    = AW'(count_q - 1'b1);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rd_d       = rd_q;
    wa_d       = wa_q;
    pos_d      = pos_q;
    key_d      = key_q;
    rd_act_d   = rd_act_q;
    pend_d     = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = wa_q;
    ram_wdata  = ram_rdata;
    ram_raddr  = rd_q;
    fin        = 1'b0;
    fin_status = STAT_OK;
    fin_rpos   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          key_d = req_i.account_key;
          unique case (req_op)
            OP_INSERT: begin
              if (eff_pos > cnt_ext) begin
                fin        = 1'b1;
                fin_status = STAT_BADPOS;
              end else if (count_q == CW'(CAPACITY)) begin
                fin        = 1'b1;
                fin_status = STAT_FULL;
              end else if (eff_pos == cnt_ext) begin
                pos_d   = AW'(eff_pos);
                state_d = S_PUT;
              end else begin
                pos_d    = AW'(eff_pos);
                rd_d     = last_idx;
                rd_act_d = 1'b1;
                state_d  = S_UP;
              end
            end
            OP_REMOVE: begin
              if (pos_ext >= cnt_ext) begin
                fin        = 1'b1;
                fin_status = STAT_BADPOS;
              end else if (pos_ext + 1'b1 == cnt_ext) begin
                count_d = count_q - 1'b1;
                fin     = 1'b1;
              end else begin
                rd_d     = AW'(pos_ext + 1'b1);
                rd_act_d = 1'b1;
                state_d  = S_DOWN;
              end
            end
            OP_SEARCH: begin
              if (count_q == '0) begin
                fin        = 1'b1;
                fin_status = STAT_NOTFOUND;
              end else begin
                rd_d     = '0;
                rd_act_d = 1'b1;
                state_d  = S_SRCH;
              end
            end
            OP_NONE: begin
              fin = 1'b1;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_UP: begin
        ram_we = pend_q;
        if (rd_act_q) begin
          pend_d = 1'b1;
          wa_d   = AW'(rd_q + 1'b1);
          if (rd_q == pos_q) begin
            rd_act_d = 1'b0;
          end else begin
            rd_d = rd_q - 1'b1;
          end
        end else begin
          state_d = S_PUT;
        end
      end
      S_DOWN: begin
        ram_we = pend_q;
        if (rd_act_q) begin
          pend_d = 1'b1;
          wa_d   = rd_q - 1'b1;
          if (rd_q == last_idx) begin
            rd_act_d = 1'b0;
          end else begin
            rd_d = rd_q + 1'b1;
          end
        end else begin
          count_d = count_q - 1'b1;
          fin     = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SRCH: begin
        if (pend_q && (ram_rdata == key_q)) begin
          fin      = 1'b1;
          fin_rpos = RPOS_W'(wa_q);
          rd_act_d = 1'b0;
          state_d  = S_IDLE;
        end else if (rd_act_q) begin
          pend_d = 1'b1;
          wa_d   = rd_q;
          if (rd_q == last_idx) begin
            rd_act_d = 1'b0;
          end else begin
            rd_d = rd_q + 1'b1;
          end
        end else begin
          fin        = 1'b1;
          fin_status = STAT_NOTFOUND;
          state_d    = S_IDLE;
        end
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = key_q;
        count_d   = count_q + 1'b1;
        fin       = 1'b1;
        fin_rpos  = RPOS_W'(pos_q);
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_rpos_d   = out_rpos_q;
    out_count_d  = out_count_q;
    if (fin) begin
      out_valid_d  = 1'b1;
      out_status_d = fin_status;
      out_rpos_d   = fin_rpos;
      out_count_d  = ECOUNT_W'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_act_q    <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_act_q    <= rd_act_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q         <= rd_d;
    wa_q         <= wa_d;
    pos_q        <= pos_d;
    key_q        <= key_d;
    out_status_q <= out_status_d;
    out_rpos_q   <= out_rpos_d;
    out_count_q  <= out_count_d;
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.status          = out_status_q;
  assign rsp_o.result_position = out_rpos_q;
  assign rsp_o.entry_count     = out_count_q;

endmodule
